// File: rtl/core/size_class_buffer_allocator_macros.svh
// Assertion helpers for the buffer allocator.
`ifndef SIZE_CLASS_BUFFER_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BUFFER_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define SCBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SCBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/scba_pkg.sv
package scba_pkg;

   localparam int unsigned NUM_CLASSES_DEF = 10;
   localparam int unsigned TOTAL_SLOTS_DEF = 1028;

   localparam int unsigned ADDR_W     = 48;
   localparam int unsigned SIZE_W     = 32;
   localparam int unsigned CLASS_W    = 4;
   localparam int unsigned HEAD_W     = 10;
   localparam int unsigned LINK_W     = 11;
   localparam int unsigned OFF_W      = 25;
   localparam int unsigned SLOT_SUM_W = 13;

   localparam logic [HEAD_W-1:0] HEAD_EMPTY = 10'h3FF;
   localparam logic [LINK_W-1:0] LINK_END   = 11'h7FF;
   localparam logic [LINK_W-1:0] LINK_USED  = 11'h7FE;

   localparam logic [ADDR_W-1:0] WIN_LO_ADDR = 48'h20_0000;
   localparam logic [ADDR_W-1:0] WIN_HI_ADDR = 48'h1E0_0000;
   localparam logic [SIZE_W-1:0] MAX_UNIT    = 32'h20_0000;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_SIZE  = 3'd1,
      ST_NO_BUF    = 3'd2,
      ST_RANGE     = 3'd3,
      ST_MISALIGN  = 3'd4,
      ST_DOUBLE    = 3'd5
   } status_type;

   // class start offset inside the region
   function automatic logic [OFF_W-1:0] cls_off_f(input logic [CLASS_W-1:0] c);
      logic [OFF_W-1:0] r;
      case (c)
         4'd0:    r = 25'h020_0000;
         4'd1:    r = 25'h040_0000;
         4'd2:    r = 25'h060_0000;
         4'd3:    r = 25'h080_0000;
         4'd4:    r = 25'h0A0_0000;
         4'd5:    r = 25'h0C0_0000;
         4'd6:    r = 25'h0E0_0000;
         4'd7:    r = 25'h100_0000;
         4'd8:    r = 25'h120_0000;
         4'd9:    r = 25'h160_0000;
         default: r = '0;
      endcase
      return r;
   endfunction

   // log2 of slot size
   function automatic logic [4:0] cls_shift_f(input logic [CLASS_W-1:0] c);
      logic [4:0] r;
      case (c)
         4'd0:    r = 5'd12;
         4'd1:    r = 5'd13;
         4'd2:    r = 5'd14;
         4'd3:    r = 5'd15;
         4'd4:    r = 5'd16;
         4'd5:    r = 5'd17;
         4'd6:    r = 5'd18;
         4'd7:    r = 5'd19;
         4'd8:    r = 5'd20;
         4'd9:    r = 5'd21;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [HEAD_W-1:0] cls_count_f(input logic [CLASS_W-1:0] c);
      logic [HEAD_W-1:0] r;
      case (c)
         4'd0:    r = 10'd512;
         4'd1:    r = 10'd256;
         4'd2:    r = 10'd128;
         4'd3:    r = 10'd64;
         4'd4:    r = 10'd32;
         4'd5:    r = 10'd16;
         4'd6:    r = 10'd8;
         4'd7:    r = 10'd4;
         4'd8:    r = 10'd4;
         4'd9:    r = 10'd4;
         default: r = '0;
      endcase
      return r;
   endfunction

   // first flat slot of a class in the link memory
   function automatic logic [LINK_W-1:0] cls_first_f(input logic [CLASS_W-1:0] c);
      logic [LINK_W-1:0] r;
      case (c)
         4'd0:    r = 11'd0;
         4'd1:    r = 11'd512;
         4'd2:    r = 11'd768;
         4'd3:    r = 11'd896;
         4'd4:    r = 11'd960;
         4'd5:    r = 11'd992;
         4'd6:    r = 11'd1008;
         4'd7:    r = 11'd1016;
         4'd8:    r = 11'd1020;
         4'd9:    r = 11'd1024;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [SIZE_W-1:0] cls_unit_f(input logic [CLASS_W-1:0] c);
      return SIZE_W'(1) << cls_shift_f(c);
   endfunction

   function automatic logic [HEAD_W-1:0] head_reset_f(input logic [CLASS_W-1:0] c);
      logic [HEAD_W-1:0] n;
      n = cls_count_f(c);
      return (n != '0) ? n - HEAD_W'(1) : HEAD_EMPTY;
   endfunction

endpackage

// File: rtl/core/scba_req_if.sv
interface scba_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [scba_pkg::SIZE_W-1:0]   alloc_size;
   logic [scba_pkg::ADDR_W-1:0]   free_address;

   modport source (output valid, cmd, alloc_size, free_address, input ready);
   modport sink   (input valid, cmd, alloc_size, free_address, output ready);
endinterface

// File: rtl/core/scba_rsp_if.sv
interface scba_rsp_if;
   logic                          valid;
   logic                          ready;
   scba_pkg::status_type          status;
   logic [scba_pkg::ADDR_W-1:0]   buffer_address;
   logic [scba_pkg::CLASS_W-1:0]  size_class;

   modport source (output valid, status, buffer_address, size_class, input ready);
   modport sink   (input valid, status, buffer_address, size_class, output ready);
endinterface

// File: rtl/core/scba_ram.sv
module scba_ram #(
   parameter int unsigned WIDTH = scba_pkg::LINK_W,
   parameter int unsigned DEPTH = scba_pkg::TOTAL_SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/size_class_buffer_allocator.sv
// Size-class buffer allocator: hands out and takes back fixed-size slots of
// a shared region, ten classes of 4 KB .. 2 MB, each a LIFO free list.
// req_bus  : one transfer per command; cmd selects allocate (alloc_size)
//            or free (free_address).
// rsp_bus  : exactly one transfer per command: status, buffer_address,
//            size_class.
// csr_wr_* : writes region_base; only while no command is in flight.
// Timing: a command is taken and the link memory is read in the same cycle;
// the execute stage then does the read-modify-write of the slot link plus the
// class head update and loads the response register once that register is free.
// A new command is taken only after the previous one has left the execute
// stage, as the link memory gets a single read-then-write pass per command.
// Reset: region_base goes to 0, the class heads to their full lists, and
// the link memory is rebuilt by a sweep of one entry per cycle; req_bus.ready
// stays low until it is done.
// Stall: the response register holds while rsp_bus.ready is low; one more
// command may be taken and then waits in the execute stage.
`include "size_class_buffer_allocator_macros.svh"

module size_class_buffer_allocator #(
   parameter int unsigned NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF,
   parameter int unsigned TOTAL_SLOTS = scba_pkg::TOTAL_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   scba_req_if.sink                    req_bus,
   scba_rsp_if.source                  rsp_bus,
   input  logic                        csr_wr_en,
   input  logic [scba_pkg::ADDR_W-1:0] csr_wr_data
);

   localparam int unsigned SLOT_W = $clog2(TOTAL_SLOTS);
   localparam int unsigned CIDX_W = $clog2(NUM_CLASSES);
   localparam int unsigned SUM_W  = scba_pkg::SLOT_SUM_W;
   localparam int unsigned ADDR_W = scba_pkg::ADDR_W;
   localparam int unsigned OFF_W  = scba_pkg::OFF_W;
   localparam int unsigned HEAD_W = scba_pkg::HEAD_W;
   localparam int unsigned LINK_W = scba_pkg::LINK_W;
   localparam int unsigned CLS_W  = scba_pkg::CLASS_W;

   // ---------------- state ----------------
   logic [ADDR_W-1:0] region_base_ff, region_base_in;
   logic [HEAD_W-1:0] head_ff [NUM_CLASSES];
   logic [HEAD_W-1:0] head_in [NUM_CLASSES];

   // link memory rebuild after reset
   logic              init_done_ff, init_done_in;
   logic [CLS_W-1:0]  init_cls_ff, init_cls_in;
   logic [HEAD_W-1:0] init_idx_ff, init_idx_in;

   // execute stage
   logic                 b_valid_ff, b_valid_in;
   logic                 b_cmd_ff, b_cmd_in;
   scba_pkg::status_type b_status_ff, b_status_in;
   logic [CLS_W-1:0]     b_cls_ff, b_cls_in;
   logic [HEAD_W-1:0]    b_head_ff, b_head_in;
   logic [HEAD_W-1:0]    b_idx_ff, b_idx_in;
   logic [SLOT_W-1:0]    b_slot_ff, b_slot_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   scba_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [CLS_W-1:0]     rsp_cls_ff, rsp_cls_in;

   // link memory ports
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   logic [LINK_W-1:0] ram_wr_data;
   logic [SLOT_W-1:0] ram_rd_addr;
   logic [LINK_W-1:0] link;

   logic req_fire;
   logic b_fire;

   assign req_bus.ready = init_done_ff && !b_valid_ff;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign b_fire        = b_valid_ff && (!rsp_valid_ff || rsp_bus.ready);

   assign region_base_in = csr_wr_en ? csr_wr_data : region_base_ff;

   // ---------------- accept stage: decode and address the link ----------------
   logic                 size_bad;
   logic [CLS_W-1:0]     fit_cls;
   logic [CLS_W-1:0]     alloc_cls;
   logic                 alloc_found;
   logic [NUM_CLASSES-1:0] avail;
   logic [SUM_W-1:0]     avail_sum [NUM_CLASSES];

   logic [ADDR_W-1:0]    free_off48;
   logic                 free_in_win;
   logic [OFF_W-1:0]     free_off;
   logic [CLS_W-1:0]     free_cls;
   logic [OFF_W-1:0]     free_mask;
   logic                 free_misalign;
   logic [OFF_W-1:0]     free_diff;
   logic [OFF_W-1:0]     free_idx_full;
   logic                 free_idx_ok;

   logic [CLS_W-1:0]     sel_cls;
   logic [HEAD_W-1:0]    sel_head;
   logic [HEAD_W-1:0]    sel_idx;
   logic [SUM_W-1:0]     sel_slot;
   logic                 sel_slot_ok;

   // a class can give a slot if its head is a real slot of the memory
   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         avail_sum[c] = SUM_W'(scba_pkg::cls_first_f(CLS_W'(c))) + SUM_W'(head_ff[c]);
         avail[c]     = (head_ff[c] != scba_pkg::HEAD_EMPTY)
                        && (head_ff[c] < scba_pkg::cls_count_f(CLS_W'(c)))
                        && (avail_sum[c] < SUM_W'(TOTAL_SLOTS));
      end
   end

   // smallest fitting class, then first non-empty one at or above it
   always_comb begin
      size_bad = (req_bus.alloc_size == '0) || (req_bus.alloc_size > scba_pkg::MAX_UNIT);
      fit_cls  = CLS_W'(NUM_CLASSES - 1);
      for (int c = NUM_CLASSES - 2; c >= 0; c--) begin
         if (req_bus.alloc_size <= scba_pkg::cls_unit_f(CLS_W'(c))) begin
            fit_cls = CLS_W'(c);
         end
      end
      alloc_found = 1'b0;
      alloc_cls   = fit_cls;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (CLS_W'(c) >= fit_cls && avail[c]) begin
            alloc_found = 1'b1;
            alloc_cls   = CLS_W'(c);
         end
      end
   end

   // free: window check, class by offset, alignment, slot index
   always_comb begin
      free_off48  = req_bus.free_address - region_base_ff;
      free_in_win = (free_off48 >= scba_pkg::WIN_LO_ADDR)
                    && (free_off48 < scba_pkg::WIN_HI_ADDR);
      free_off    = free_off48[OFF_W-1:0];
      free_cls    = '0;
      for (int c = 1; c < NUM_CLASSES; c++) begin
         if (scba_pkg::cls_off_f(CLS_W'(c)) != '0
             && free_off >= scba_pkg::cls_off_f(CLS_W'(c))) begin
            free_cls = CLS_W'(c);
         end
      end
      // class offsets are 2 MB aligned, so the low bits decide alignment
      free_mask     = (OFF_W'(1) << scba_pkg::cls_shift_f(free_cls)) - OFF_W'(1);
      free_misalign = |(free_off & free_mask);
      free_diff     = free_off - scba_pkg::cls_off_f(free_cls);
      free_idx_full = free_diff >> scba_pkg::cls_shift_f(free_cls);
      free_idx_ok   = free_idx_full < OFF_W'(scba_pkg::cls_count_f(free_cls));
   end

   // one head read and one slot adder shared by both commands
   always_comb begin
      sel_cls     = (req_bus.cmd == scba_pkg::CMD_FREE) ? free_cls : alloc_cls;
      sel_head    = head_ff[sel_cls[CIDX_W-1:0]];
      sel_idx     = (req_bus.cmd == scba_pkg::CMD_FREE) ? free_idx_full[HEAD_W-1:0]
                                                        : sel_head;
      sel_slot    = SUM_W'(scba_pkg::cls_first_f(sel_cls)) + SUM_W'(sel_idx);
      sel_slot_ok = sel_slot < SUM_W'(TOTAL_SLOTS);
      ram_rd_addr = sel_slot[SLOT_W-1:0];
   end

   // early status; execute stage may still turn a free into double free
   always_comb begin
      b_cmd_in    = b_cmd_ff;
      b_status_in = b_status_ff;
      b_cls_in    = b_cls_ff;
      b_head_in   = b_head_ff;
      b_idx_in    = b_idx_ff;
      b_slot_in   = b_slot_ff;
      if (req_fire) begin
         b_cmd_in  = req_bus.cmd;
         b_head_in = sel_head;
         b_idx_in  = free_idx_full[HEAD_W-1:0];
         b_slot_in = sel_slot[SLOT_W-1:0];
         if (req_bus.cmd == scba_pkg::CMD_ALLOC) begin
            if (size_bad) begin
               b_status_in = scba_pkg::ST_BAD_SIZE;
               b_cls_in    = '0;
            end else if (!alloc_found) begin
               b_status_in = scba_pkg::ST_NO_BUF;
               b_cls_in    = fit_cls;
            end else begin
               b_status_in = scba_pkg::ST_OK;
               b_cls_in    = alloc_cls;
            end
         end else begin
            if (!free_in_win) begin
               b_status_in = scba_pkg::ST_RANGE;
               b_cls_in    = '0;
            end else if (free_misalign) begin
               b_status_in = scba_pkg::ST_MISALIGN;
               b_cls_in    = free_cls;
            end else if (!(free_idx_ok && sel_slot_ok)) begin
               b_status_in = scba_pkg::ST_DOUBLE;
               b_cls_in    = free_cls;
            end else begin
               b_status_in = scba_pkg::ST_OK;
               b_cls_in    = free_cls;
            end
         end
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (req_fire) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end
   end

   // ---------------- execute stage: link read-modify-write ----------------
   logic                 b_ok;
   logic                 alloc_ok;
   logic                 free_ok;
   scba_pkg::status_type b_final;
   logic [OFF_W-1:0]     alloc_off;
   logic [ADDR_W-1:0]    alloc_addr;
   logic                 item_we;
   logic [HEAD_W-1:0]    head_wr_data;
   logic [LINK_W-1:0]    link_wr_data;

   always_comb begin
      b_ok     = (b_status_ff == scba_pkg::ST_OK);
      alloc_ok = b_ok && (b_cmd_ff == scba_pkg::CMD_ALLOC);
      free_ok  = b_ok && (b_cmd_ff == scba_pkg::CMD_FREE) && (link == scba_pkg::LINK_USED);
      b_final  = (b_ok && (b_cmd_ff == scba_pkg::CMD_FREE) && (link != scba_pkg::LINK_USED))
                 ? scba_pkg::ST_DOUBLE : b_status_ff;
      alloc_off  = scba_pkg::cls_off_f(b_cls_ff)
                   + (OFF_W'(b_head_ff) << scba_pkg::cls_shift_f(b_cls_ff));
      alloc_addr = region_base_ff + ADDR_W'(alloc_off);
      item_we    = b_fire && (alloc_ok || free_ok);
      if (alloc_ok) begin
         head_wr_data = (link == scba_pkg::LINK_END) ? scba_pkg::HEAD_EMPTY
                                                     : link[HEAD_W-1:0];
         link_wr_data = scba_pkg::LINK_USED;
      end else begin
         head_wr_data = b_idx_ff;
         link_wr_data = (b_head_ff == scba_pkg::HEAD_EMPTY) ? scba_pkg::LINK_END
                                                            : LINK_W'(b_head_ff);
      end
   end

   always_comb begin
      head_in = head_ff;
      if (item_we) begin
         head_in[b_cls_ff[CIDX_W-1:0]] = head_wr_data;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_cls_in    = rsp_cls_ff;
      if (b_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = b_final;
         rsp_addr_in   = alloc_ok ? alloc_addr : '0;
         rsp_cls_in    = b_cls_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   // ---------------- link rebuild sweep ----------------
   logic [HEAD_W-1:0] init_count;
   logic [SUM_W-1:0]  init_slot;
   logic              init_we;
   logic              init_last;
   logic [LINK_W-1:0] init_data;

   always_comb begin
      init_count = scba_pkg::cls_count_f(init_cls_ff);
      init_slot  = SUM_W'(scba_pkg::cls_first_f(init_cls_ff)) + SUM_W'(init_idx_ff);
      init_we    = !init_done_ff && (init_count != '0) && (init_slot < SUM_W'(TOTAL_SLOTS));
      init_last  = (init_count == '0) || (init_idx_ff == init_count - HEAD_W'(1));
      init_data  = (init_idx_ff == '0) ? scba_pkg::LINK_END
                                       : LINK_W'(init_idx_ff - HEAD_W'(1));
      init_done_in = init_done_ff;
      init_cls_in  = init_cls_ff;
      init_idx_in  = init_idx_ff;
      if (!init_done_ff) begin
         if (init_last) begin
            init_idx_in = '0;
            if (init_cls_ff == CLS_W'(NUM_CLASSES - 1)) begin
               init_done_in = 1'b1;
            end else begin
               init_cls_in = init_cls_ff + CLS_W'(1);
            end
         end else begin
            init_idx_in = init_idx_ff + HEAD_W'(1);
         end
      end
   end

   always_comb begin
      if (!init_done_ff) begin
         ram_wr_en   = init_we;
         ram_wr_addr = init_slot[SLOT_W-1:0];
         ram_wr_data = init_data;
      end else begin
         ram_wr_en   = item_we;
         ram_wr_addr = b_slot_ff;
         ram_wr_data = link_wr_data;
      end
   end

   scba_ram #(
      .WIDTH (LINK_W),
      .DEPTH (TOTAL_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (ram_rd_addr),
      .rd_data (link)
   );

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= '0;
         init_done_ff   <= 1'b0;
         init_cls_ff    <= '0;
         init_idx_ff    <= '0;
         b_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c] <= scba_pkg::head_reset_f(CLS_W'(c));
         end
      end else begin
         region_base_ff <= region_base_in;
         init_done_ff   <= init_done_in;
         init_cls_ff    <= init_cls_in;
         init_idx_ff    <= init_idx_in;
         b_valid_ff     <= b_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         head_ff        <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      b_cmd_ff      <= b_cmd_in;
      b_status_ff   <= b_status_in;
      b_cls_ff      <= b_cls_in;
      b_head_ff     <= b_head_in;
      b_idx_ff      <= b_idx_in;
      b_slot_ff     <= b_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_cls_ff    <= rsp_cls_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.buffer_address = rsp_addr_ff;
   assign rsp_bus.size_class     = rsp_cls_ff;

   // ---------------- checks ----------------
   `SCBA_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_bus.valid && req_bus.ready, b_valid_ff, "accepted transfer missing from execute stage")
   `SCBA_ASSERT_NOW(a_idle_during_sweep, clock, reset, !init_done_ff, !b_valid_ff && !rsp_valid_ff, "command in flight during link rebuild")
   `SCBA_ASSERT_NOW(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff), $past(b_valid_ff), "response without a command in execute")
   `SCBA_ASSERT_NOW(a_addr_zero_on_error, clock, reset, rsp_valid_ff && rsp_status_ff != scba_pkg::ST_OK, rsp_addr_ff == '0, "nonzero address on failed command")

endmodule

// File: tb/tb_size_class_buffer_allocator.sv
`timescale 1ns / 1ps

// Testbench for the size-class buffer allocator.
// Flow: an initial block posts commands into cmd_queue a few at a time; the
// driver turns them into req transfers on the falling edge; the monitor
// samples both channels on the rising edge. Every accepted command runs
// through run_allocator (the free lists kept here), and the result it
// yields waits in owed_results until the matching rsp transfer arrives.
module tb_size_class_buffer_allocator;
   import scba_pkg::*;

   // geometry of the region, kept apart from the package tables
   localparam int unsigned CLASSES       = 10;
   localparam int unsigned SLOTS         = 1028;
   localparam logic [47:0] CLASS_STRIDE  = 48'h20_0000;
   localparam logic [47:0] TOP_CLASS_OFF = 48'h160_0000;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          PHASE_ITEMS   = 170;

   typedef struct packed {
      logic              cmd;
      logic [SIZE_W-1:0] alloc_size;
      logic [ADDR_W-1:0] free_address;
   } command_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  buffer_address;
      logic [CLASS_W-1:0] size_class;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [ADDR_W-1:0] csr_wr_data;

   scba_req_if req_if ();
   scba_rsp_if rsp_if ();

   size_class_buffer_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // allocator state as the testbench sees it
   logic [ADDR_W-1:0] base_addr;
   logic [HEAD_W-1:0] free_top [CLASSES];
   logic [LINK_W-1:0] next_free [SLOTS];
   int unsigned       first_slot [CLASSES];

   command_type       cmd_queue [$];
   result_type        owed_results [$];
   logic [47:0]       live_offsets [$];   // offsets of slots handed out, for frees

   int  items_queued = 0;
   int  items_taken  = 0;
   int  mismatches   = 0;
   int  cycle_count  = 0;
   logic req_taken   = 1'b0;
   logic rsp_taken   = 1'b0;
   int  send_wait    = 0;
   int  send_streak  = 0;
   int  recv_hold    = 0;
   int  recv_streak  = 0;

   function automatic int unsigned class_shift(input int unsigned c);
      return 12 + c;
   endfunction

   function automatic int unsigned class_slots(input int unsigned c);
      return (c < 7) ? (512 >> c) : 4;
   endfunction

   function automatic logic [47:0] class_offset(input int unsigned c);
      return (c == CLASSES - 1) ? TOP_CLASS_OFF : CLASS_STRIDE * 48'(c + 1);
   endfunction

   // full lists after reset: top slot first, each slot points one below
   function automatic void restore_free_lists();
      int unsigned c, j, acc;
      acc = 0;
      base_addr = '0;
      for (j = 0; j < SLOTS; j++) next_free[j] = LINK_END;
      for (c = 0; c < CLASSES; c++) begin
         first_slot[c] = acc;
         free_top[c] = HEAD_W'(class_slots(c) - 1);
         for (j = 0; j < class_slots(c); j++)
            next_free[acc + j] = (j == 0) ? LINK_END : LINK_W'(j - 1);
         acc += class_slots(c);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
   endtask

   // one command against the free lists; returns the result it must give
   task automatic run_allocator(input logic cmd, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] addr, output result_type res);
      int unsigned c, k, h, s;
      logic [47:0] off, diff;
      logic found;
      res.status = ST_OK;
      res.buffer_address = '0;
      res.size_class = '0;
      if (cmd == CMD_ALLOC) begin
         if (size == 0 || size > MAX_UNIT) begin
            res.status = ST_BAD_SIZE;
         end else begin
            c = 0;
            while (c < CLASSES - 1 && size > (32'd1 << class_shift(c))) c++;
            res.size_class = CLASS_W'(c);
            found = 1'b0;
            // fitting class empty: spill upward to the next class with a slot
            for (k = c; k < CLASSES && !found; k++) begin
               if (free_top[k] != HEAD_EMPTY) begin
                  h = free_top[k];
                  s = first_slot[k] + h;
                  free_top[k] = (next_free[s] == LINK_END) ? HEAD_EMPTY
                                                           : next_free[s][HEAD_W-1:0];
                  next_free[s] = LINK_USED;
                  off = class_offset(k) + (48'(h) << class_shift(k));
                  res.buffer_address = base_addr + off;
                  res.size_class = CLASS_W'(k);
                  live_offsets.push_back(off);
                  found = 1'b1;
               end
            end
            if (!found) res.status = ST_NO_BUF;
         end
      end else begin
         off = addr - base_addr;   // wraps modulo 2^48
         if (off < WIN_LO_ADDR || off >= WIN_HI_ADDR) begin
            res.status = ST_RANGE;
         end else begin
            c = 0;
            while (c < CLASSES - 1 && off >= class_offset(c + 1)) c++;
            res.size_class = CLASS_W'(c);
            diff = off - class_offset(c);
            if ((diff & ((48'd1 << class_shift(c)) - 48'd1)) != 0) begin
               res.status = ST_MISALIGN;
            end else begin
               h = int'(diff >> class_shift(c));
               s = first_slot[c] + h;
               if (h >= class_slots(c) || next_free[s] != LINK_USED) begin
                  res.status = ST_DOUBLE;
               end else begin
                  next_free[s] = (free_top[c] == HEAD_EMPTY) ? LINK_END
                                                             : LINK_W'(free_top[c]);
                  free_top[c] = HEAD_W'(h);
               end
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: rsp check first, then predict the command taken this edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      result_type want;
      req_taken <= !reset && req_if.valid && req_if.ready;
      rsp_taken <= !reset && rsp_if.valid && rsp_if.ready;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (owed_results.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_if.buffer_address), 64'd0);
         end else begin
            want = owed_results.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
            if (rsp_if.buffer_address !== want.buffer_address)
               report_mismatch("buffer_address", 64'(rsp_if.buffer_address),
                               64'(want.buffer_address));
            if (rsp_if.size_class !== want.size_class)
               report_mismatch("size_class", 64'(rsp_if.size_class),
                               64'(want.size_class));
         end
      end
      if (!reset && req_if.valid && req_if.ready) begin
         run_allocator(req_if.cmd, req_if.alloc_size, req_if.free_address, want);
         owed_results.push_back(want);
         items_taken++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driver: holds a command until its transfer, then waits its gap.
   // Gaps are drawn at random, with runs of back-to-back transfers mixed in.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      command_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_taken) begin
         // transfer still pending, keep everything steady
      end else if (send_wait > 0) begin
         req_if.valid <= 1'b0;
         send_wait <= send_wait - 1;
      end else if (cmd_queue.size() != 0) begin
         item = cmd_queue.pop_front();
         req_if.cmd          <= item.cmd;
         req_if.alloc_size   <= item.alloc_size;
         req_if.free_address <= item.free_address;
         req_if.valid        <= 1'b1;
         if (send_streak > 0) begin
            send_streak <= send_streak - 1;
            send_wait <= 0;
         end else begin
            if ($urandom_range(0, 15) == 0) send_streak <= $urandom_range(10, 40);
            send_wait <= $urandom_range(0, 7);
         end
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // Receiver: after each rsp transfer, drop ready for a random stall (or none in a run).
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if (recv_streak > 0) begin
               recv_streak--;
               recv_hold = 0;
            end else begin
               if ($urandom_range(0, 15) == 0) recv_streak = $urandom_range(10, 40);
               recv_hold = $urandom_range(0, 7);
            end
         end
         if (recv_hold > 0) begin
            rsp_if.ready <= 1'b0;
            recv_hold--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   // keep only a short lookahead so frees can target slots handed out lately
   task automatic post_command(input logic cmd, input logic [SIZE_W-1:0] size,
                               input logic [ADDR_W-1:0] addr);
      command_type item;
      while (items_queued - items_taken >= 3) @(negedge clock);
      item.cmd = cmd;
      item.alloc_size = size;
      item.free_address = addr;
      cmd_queue.push_back(item);
      items_queued++;
   endtask

   // block quiet: everything sent, taken and answered, plus pipeline slack
   task automatic wait_idle();
      do @(negedge clock);
      while (items_taken != items_queued || owed_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_region_base(input logic [ADDR_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      base_addr = value;
   endtask

   // mostly well-formed allocate/free traffic; the rest is error cases
   task automatic post_random_command();
      int unsigned pick, c, idx, n;
      logic [SIZE_W-1:0] unit;
      logic [47:0] off, delta;
      pick = $urandom_range(0, 99);
      c = $urandom_range(0, CLASSES - 1);
      unit = 32'd1 << class_shift(c);
      idx = $urandom_range(0, class_slots(c) - 1);
      off = class_offset(c) + (48'(idx) << class_shift(c));
      if (pick >= 50 && pick < 85 && live_offsets.size() != 0) begin
         n = $urandom_range(0, live_offsets.size() - 1);
         post_command(CMD_FREE, $urandom, base_addr + live_offsets[n]);
         live_offsets.delete(n);
      end else if (pick < 85) begin
         post_command(CMD_ALLOC, $urandom_range((c == 0) ? 1 : (unit >> 1) + 1, unit),
                      48'({$urandom, $urandom}));
      end else begin
         case ($urandom_range(0, 4))
            0: post_command(CMD_ALLOC, $urandom, 48'({$urandom, $urandom}));
            1: post_command(CMD_FREE, $urandom, 48'({$urandom, $urandom}));
            2: post_command(CMD_FREE, $urandom,
                            base_addr + off + 48'($urandom_range(1, unit - 1)));
            3: post_command(CMD_FREE, $urandom, base_addr + off);
            default: begin
               // just outside the window: below it, above it, or below the base
               n = $urandom_range(0, 2);
               if (n == 0)
                  delta = 48'($urandom_range(0, 32'h1F_FFFF));
               else if (n == 1)
                  delta = WIN_HI_ADDR + 48'($urandom_range(0, 32'hFFFF));
               else
                  delta = 48'd0 - 48'($urandom_range(1, 32'hFFFF));
               post_command(CMD_FREE, $urandom, base_addr + delta);
            end
         endcase
      end
   endtask

   initial begin : run_test
      int ph;
      logic [ADDR_W-1:0] value;
      req_if.valid        = 1'b0;
      req_if.cmd          = CMD_ALLOC;
      req_if.alloc_size   = '0;
      req_if.free_address = '0;
      rsp_if.ready        = 1'b0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      restore_free_lists();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed part, region base at its reset value of zero.
      post_command(CMD_ALLOC, 32'd0, '0);              // zero size
      post_command(CMD_ALLOC, MAX_UNIT + 32'd1, '1);   // one byte over 2 MB
      post_command(CMD_ALLOC, 32'hFFFF_FFFF, '0);      // largest size field
      post_command(CMD_ALLOC, 32'd1, '0);              // smallest size, 4 KB class
      post_command(CMD_ALLOC, 32'h1000, '0);           // exact unit
      post_command(CMD_ALLOC, 32'h1001, '0);           // one over, 8 KB class
      repeat (5) post_command(CMD_ALLOC, 32'h10_0000, '0); // fifth spills to 2 MB
      repeat (3) post_command(CMD_ALLOC, MAX_UNIT, '0);    // drains the 2 MB class
      post_command(CMD_ALLOC, MAX_UNIT, '0);           // exhausted
      post_command(CMD_ALLOC, 32'h8_0001, '0);         // 1 MB and up all empty
      post_command(CMD_FREE, '0, WIN_HI_ADDR - CLASS_STRIDE); // top 2 MB slot back
      post_command(CMD_FREE, '0, WIN_HI_ADDR - CLASS_STRIDE); // same slot again
      post_command(CMD_FREE, '1, WIN_LO_ADDR - 48'd1); // just under the window
      post_command(CMD_FREE, '0, WIN_HI_ADDR);         // just past the window
      post_command(CMD_FREE, '0, WIN_LO_ADDR + 48'd1); // misaligned
      post_command(CMD_FREE, '0, WIN_LO_ADDR);         // never handed out
      post_command(CMD_FREE, '0, '1);                  // all-ones address
      post_command(CMD_FREE, '0, WIN_LO_ADDR + 48'h1F_F000); // first 4 KB buffer
      post_command(CMD_ALLOC, MAX_UNIT, '0);           // LIFO: gets the freed 2 MB slot

      // Random phases, each under a different region base. Every base change
      // waits for the block to drain, which also holds the sender off.
      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0: value = '0;
            1: value = '1;
            2: value = 48'hFFFF_FF00_0000;   // window wraps past the top
            3: value = 48'({$urandom, $urandom});
            default: value = 48'({$urandom, $urandom}) & ~48'hFFF;
         endcase
         write_region_base(value);
         repeat (PHASE_ITEMS) post_random_command();
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/scba_pkg.sv
rtl/core/scba_req_if.sv
rtl/core/scba_rsp_if.sv
rtl/core/scba_ram.sv
rtl/core/size_class_buffer_allocator.sv
tb/tb_size_class_buffer_allocator.sv
